### rtl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Shared constants, operand tables and the flag bundle of the segment
// crossing pipeline.
// ----------------------------------------------------------------------------
package sct_pkg;

    // Default coordinate width
    localparam int unsigned COORD_BITS_DEF = 16;

    // Coordinate slots: A, B, C, D, x then y
    localparam int unsigned NUM_COORDS = 8;
    localparam int unsigned C_AX = 0;
    localparam int unsigned C_AY = 1;
    localparam int unsigned C_BX = 2;
    localparam int unsigned C_BY = 3;
    localparam int unsigned C_CX = 4;
    localparam int unsigned C_CY = 5;
    localparam int unsigned C_DX = 6;
    localparam int unsigned C_DY = 7;

    // Difference vectors: diff[i] = coord[DIFF_MIN[i]] - coord[DIFF_SUB[i]]
    // order: AB, CB, DB, CD, AD, BD, AC, BC, CA, DA (x then y each)
    localparam int unsigned NUM_DIFFS = 20;
    localparam int unsigned DIFF_MIN [NUM_DIFFS] = '{
        C_BX, C_BY, C_CX, C_CY, C_DX, C_DY, C_DX, C_DY, C_AX, C_AY,
        C_BX, C_BY, C_AX, C_AY, C_BX, C_BY, C_CX, C_CY, C_DX, C_DY
    };
    localparam int unsigned DIFF_SUB [NUM_DIFFS] = '{
        C_AX, C_AY, C_BX, C_BY, C_BX, C_BY, C_CX, C_CY, C_DX, C_DY,
        C_DX, C_DY, C_CX, C_CY, C_CX, C_CY, C_AX, C_AY, C_AX, C_AY
    };

    // Products: prod[i] = diff[MUL_L[i]] * diff[MUL_R[i]]
    // terms 0..3 are cross products (even minus odd), 4..7 dot products
    localparam int unsigned NUM_PRODS = 16;
    localparam int unsigned MUL_L [NUM_PRODS] = '{
        0, 1, 0, 1, 6, 7, 6, 7, 12, 13, 8, 9, 16, 17, 2, 3
    };
    localparam int unsigned MUL_R [NUM_PRODS] = '{
        3, 2, 5, 4, 9, 8, 11, 10, 14, 15, 10, 11, 18, 19, 4, 5
    };

    // Terms
    localparam int unsigned NUM_TERMS  = 8;
    localparam int unsigned NUM_CROSS  = 4;
    localparam int unsigned K_P  = 0;   // C against AB
    localparam int unsigned K_Q  = 1;   // D against AB
    localparam int unsigned K_R  = 2;   // A against CD
    localparam int unsigned K_S  = 3;   // B against CD
    localparam int unsigned K_DC = 4;   // (A-C).(B-C)
    localparam int unsigned K_DD = 5;   // (A-D).(B-D)
    localparam int unsigned K_DA = 6;   // (C-A).(D-A)
    localparam int unsigned K_DB = 7;   // (C-B).(D-B)

    // Sign flags of all terms plus the mode bit
    typedef struct packed {
        logic                 strict;
        logic [NUM_TERMS-1:0] neg;
        logic [NUM_TERMS-1:0] zero;
    } sct_flags_t;

endpackage

### rtl/sct_diff.sv
// ----------------------------------------------------------------------------
// sct_diff
// Stage 1: sign-extends the coordinates and registers all difference vectors.
// ----------------------------------------------------------------------------
module sct_diff #(
    parameter int unsigned COORD_BITS = sct_pkg::COORD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [COORD_BITS-1:0] coord_i [sct_pkg::NUM_COORDS],
    input  logic                    strict_i,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [COORD_BITS:0]   diff_o [sct_pkg::NUM_DIFFS],
    output logic                    strict_o
);
    import sct_pkg::*;

    logic                      valid_reg;
    logic                      strict_reg;
    logic signed [COORD_BITS:0] diff_reg  [NUM_DIFFS];
    logic signed [COORD_BITS:0] diff_next [NUM_DIFFS];

    // Stage moves when empty or when downstream takes the beat
    assign in_ready = !valid_reg || out_ready;

    // Differences, one bit wider than the coordinates
    always_comb begin
        for (int i = 0; i < NUM_DIFFS; i++) begin
            diff_next[i] = {coord_i[DIFF_MIN[i]][COORD_BITS-1], coord_i[DIFF_MIN[i]]}
                         - {coord_i[DIFF_SUB[i]][COORD_BITS-1], coord_i[DIFF_SUB[i]]};
        end
    end

    // Valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            diff_reg   <= diff_next;
            strict_reg <= strict_i;
        end
    end

    assign out_valid = valid_reg;
    assign diff_o    = diff_reg;
    assign strict_o  = strict_reg;

endmodule

### rtl/sct_mult.sv
// ----------------------------------------------------------------------------
// sct_mult
// Stage 2: sixteen parallel signed multipliers, one per cross/dot term half.
// ----------------------------------------------------------------------------
module sct_mult #(
    parameter int unsigned COORD_BITS = sct_pkg::COORD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [COORD_BITS:0]       diff_i [sct_pkg::NUM_DIFFS],
    input  logic                    strict_i,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [2*COORD_BITS+1:0]   prod_o [sct_pkg::NUM_PRODS],
    output logic                    strict_o
);
    import sct_pkg::*;

    logic                             valid_reg;
    logic                             strict_reg;
    logic signed [2*COORD_BITS+1:0]   prod_reg  [NUM_PRODS];
    logic signed [2*COORD_BITS+1:0]   prod_next [NUM_PRODS];

    assign in_ready = !valid_reg || out_ready;

    // Independent lanes, operands picked by the package tables
    always_comb begin
        for (int i = 0; i < NUM_PRODS; i++) begin
            prod_next[i] = diff_i[MUL_L[i]] * diff_i[MUL_R[i]];
        end
    end

    // Valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            prod_reg   <= prod_next;
            strict_reg <= strict_i;
        end
    end

    assign out_valid = valid_reg;
    assign prod_o    = prod_reg;
    assign strict_o  = strict_reg;

endmodule

### rtl/sct_sign.sv
// ----------------------------------------------------------------------------
// sct_sign
// Stage 3: combines product pairs into cross and dot terms and registers
// their sign and zero flags.
// ----------------------------------------------------------------------------
module sct_sign #(
    parameter int unsigned COORD_BITS = sct_pkg::COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [2*COORD_BITS+1:0] prod_i [sct_pkg::NUM_PRODS],
    input  logic                  strict_i,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sct_pkg::sct_flags_t   flags_o
);
    import sct_pkg::*;

    localparam int unsigned SW = 2 * COORD_BITS + 3;

    logic                 valid_reg;
    sct_flags_t           flags_reg;
    sct_flags_t           flags_next;
    logic signed [SW-1:0] term [NUM_TERMS];

    assign in_ready = !valid_reg || out_ready;

    // Cross terms subtract, dot terms add; then sign and zero tests
    always_comb begin
        flags_next.strict = strict_i;
        for (int k = 0; k < NUM_TERMS; k++) begin
            if (k < NUM_CROSS) begin
                term[k] = SW'(prod_i[2*k]) - SW'(prod_i[2*k+1]);
            end else begin
                term[k] = SW'(prod_i[2*k]) + SW'(prod_i[2*k+1]);
            end
            flags_next.neg[k]  = term[k][SW-1];
            flags_next.zero[k] = (term[k] == '0);
        end
    end

    // Valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign flags_o   = flags_reg;

endmodule

### rtl/segment_crossing_test_top.sv
// ----------------------------------------------------------------------------
// segment_crossing_test_top
// Segment intersection test: four pipeline stages, one pair per cycle while m_ready is high.
//
// Usage:
//   Input channel s_*: one beat carries segment AB (s_a_*, s_b_*), segment
//   CD (s_c_*, s_d_*) as signed COORD_BITS coordinates and s_strict_mode.
//   Output channel m_*: one beat per input beat, in order, m_crosses = 1
//   when the segments meet (inclusive) or cross properly (strict).
//   Path: an accepted beat reaches m_valid through the difference,
//   multiply, sign and decision stage registers, in that order.
//   Throughput: one pair per cycle while m_ready is high; each stage
//   holds one beat.
//   Stall: when m_ready is low, stages fill from the output backwards and
//   s_ready drops only once every stage holds a beat; no beat is lost or
//   repeated, and idle stages collapse bubbles.
//   Reset: aresetn low clears all valid bits; the pipeline is empty and
//   ready on the first cycle after reset.
// ----------------------------------------------------------------------------
module segment_crossing_test_top #(
    parameter int unsigned COORD_BITS = sct_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_a_x,
    input  logic signed [COORD_BITS-1:0] s_a_y,
    input  logic signed [COORD_BITS-1:0] s_b_x,
    input  logic signed [COORD_BITS-1:0] s_b_y,
    input  logic signed [COORD_BITS-1:0] s_c_x,
    input  logic signed [COORD_BITS-1:0] s_c_y,
    input  logic signed [COORD_BITS-1:0] s_d_x,
    input  logic signed [COORD_BITS-1:0] s_d_y,
    input  logic                         s_strict_mode,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_crosses
);
    import sct_pkg::*;

    logic signed [COORD_BITS-1:0]   coord [NUM_COORDS];
    logic signed [COORD_BITS:0]     diff  [NUM_DIFFS];
    logic signed [2*COORD_BITS+1:0] prod  [NUM_PRODS];
    logic       diff_valid, diff_ready, diff_strict;
    logic       mult_valid, mult_ready, mult_strict;
    logic       sign_valid, out_stage_ready;
    sct_flags_t sign_flags;

    logic m_valid_reg;
    logic crosses_reg;
    logic crosses_next;

    // Coordinate bundle
    assign coord[C_AX] = s_a_x;
    assign coord[C_AY] = s_a_y;
    assign coord[C_BX] = s_b_x;
    assign coord[C_BY] = s_b_y;
    assign coord[C_CX] = s_c_x;
    assign coord[C_CY] = s_c_y;
    assign coord[C_DX] = s_d_x;
    assign coord[C_DY] = s_d_y;

    // Stage 1: differences
    sct_diff #(.COORD_BITS(COORD_BITS)) u_diff (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .coord_i   (coord),
        .strict_i  (s_strict_mode),
        .out_valid (diff_valid),
        .out_ready (diff_ready),
        .diff_o    (diff),
        .strict_o  (diff_strict)
    );

    // Stage 2: products
    sct_mult #(.COORD_BITS(COORD_BITS)) u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (diff_valid),
        .in_ready  (diff_ready),
        .diff_i    (diff),
        .strict_i  (diff_strict),
        .out_valid (mult_valid),
        .out_ready (mult_ready),
        .prod_o    (prod),
        .strict_o  (mult_strict)
    );

    // Stage 3: term signs
    sct_sign #(.COORD_BITS(COORD_BITS)) u_sign (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mult_valid),
        .in_ready  (mult_ready),
        .prod_i    (prod),
        .strict_i  (mult_strict),
        .out_valid (sign_valid),
        .out_ready (out_stage_ready),
        .flags_o   (sign_flags)
    );

    // Stage 4: decision from the sign flags
    always_comb begin
        logic p_neg, q_neg, r_neg, s_neg;
        logic p_pos, q_pos, r_pos, s_pos;
        logic collinear, on_seg, incl_hit, strict_hit;
        p_neg = sign_flags.neg[K_P];
        q_neg = sign_flags.neg[K_Q];
        r_neg = sign_flags.neg[K_R];
        s_neg = sign_flags.neg[K_S];
        p_pos = !p_neg && !sign_flags.zero[K_P];
        q_pos = !q_neg && !sign_flags.zero[K_Q];
        r_pos = !r_neg && !sign_flags.zero[K_R];
        s_pos = !s_neg && !sign_flags.zero[K_S];
        collinear = sign_flags.zero[K_P] && sign_flags.zero[K_Q];
        // endpoint on the other segment: zero cross term and dot <= 0
        on_seg = (sign_flags.zero[K_P] && (sign_flags.neg[K_DC] || sign_flags.zero[K_DC]))
              || (sign_flags.zero[K_Q] && (sign_flags.neg[K_DD] || sign_flags.zero[K_DD]))
              || (sign_flags.zero[K_R] && (sign_flags.neg[K_DA] || sign_flags.zero[K_DA]))
              || (sign_flags.zero[K_S] && (sign_flags.neg[K_DB] || sign_flags.zero[K_DB]));
        incl_hit   = !((p_neg && q_neg) || (p_pos && q_pos))
                  && !((r_neg && s_neg) || (r_pos && s_pos));
        strict_hit = ((p_pos && q_neg) || (p_neg && q_pos))
                  && ((r_pos && s_neg) || (r_neg && s_pos));
        if (collinear) begin
            crosses_next = !sign_flags.strict && on_seg;
        end else if (sign_flags.strict) begin
            crosses_next = strict_hit;
        end else begin
            crosses_next = incl_hit;
        end
    end

    assign out_stage_ready = !m_valid_reg || m_ready;

    // Output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_stage_ready) begin
            m_valid_reg <= sign_valid;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (sign_valid && out_stage_ready) begin
            crosses_reg <= crosses_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_crosses = crosses_reg;

`ifndef SYNTHESIS
    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // A beat leaving stage 3 lands in the output register
    a_stage_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        (sign_valid && out_stage_ready) |=> m_valid)
        else $error("beat lost between stage 3 and output");

    // Strict mode never reports a collinear pair
    a_strict_collinear: assert property (@(posedge aclk) disable iff (!aresetn)
        (sign_valid && out_stage_ready && sign_flags.strict
         && sign_flags.zero[K_P] && sign_flags.zero[K_Q]) |=> !m_crosses)
        else $error("strict collinear pair reported as crossing");

    // C and D both strictly on the negative side of AB never cross
    a_same_side: assert property (@(posedge aclk) disable iff (!aresetn)
        (sign_valid && out_stage_ready
         && sign_flags.neg[K_P] && sign_flags.neg[K_Q]) |=> !m_crosses)
        else $error("same-side pair reported as crossing");
`endif

endmodule
